// File: hw/rtl/elevation_grid_mesher_defines.svh
// ----------------------------------------------------------------------------
// Elevation grid mesher assertion macros
// Concurrent check wrappers shared by the mesher RTL.
// ----------------------------------------------------------------------------
`ifndef ELEVATION_GRID_MESHER_DEFINES_SVH
`define ELEVATION_GRID_MESHER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define EGM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("egm check failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define EGM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("egm check failed: next-cycle implication");
`else
`define EGM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EGM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/egm_pkg.sv
// ----------------------------------------------------------------------------
// Elevation grid mesher package
// Field widths, register indexes, reset values and result codes.
// ----------------------------------------------------------------------------
package egm_pkg;

    localparam int DEF_MAX_DIM = 1024;

    localparam int CFG_DIM_W   = 11;
    localparam int SPACING_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int HEIGHT_W    = 16;
    localparam int POS_W       = 26;
    localparam int VCOUNT_W    = 21;
    localparam int CORNER_W    = 20;
    localparam int KIND_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_X_COLUMNS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_ROWS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_X_SPACING  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_SPACING  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CCW        = 3'd4;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0] RST_X_COLUMNS = 11'd16;
    localparam logic [CFG_DIM_W-1:0] RST_Z_ROWS    = 11'd16;
    localparam logic [SPACING_W-1:0] RST_X_SPACING = 16'd256;
    localparam logic [SPACING_W-1:0] RST_Z_SPACING = 16'd256;
    localparam logic                 RST_CCW       = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_MISMATCH = 2'd2
    } t_kind;

    // Result slots of one sample, in emission order
    localparam logic [1:0] SLOT_FIRST      = 2'd0;
    localparam logic [1:0] SLOT_TRI_FIRST  = 2'd1;
    localparam logic [1:0] SLOT_TRI_SECOND = 2'd2;

endpackage

// File: hw/rtl/elevation_grid_mesher.sv
// ----------------------------------------------------------------------------
// Elevation grid mesher
// Turns a row-major stream of height samples into mesh vertices and triangles.
// ----------------------------------------------------------------------------
// Each accepted height sample produces one vertex result (column * x_spacing,
// height, row * z_spacing); a sample with column and row both nonzero closes a
// grid cell and is followed right away by that cell's two triangles (vertex
// indices, wound by counter_clockwise). The last_sample mark is checked
// against x_columns * z_rows: a mismatch yields a single mismatch result, and
// a missing mark drops further samples up to the next marked one. A sample
// is taken and its results are computed in a single pass into a small
// result buffer that drains through one output register, one result per
// cycle while i_out_stall is low. A sample therefore yields one result
// (plain vertex or mismatch), three results (vertex and two triangles) or
// none (dropped), and the next request is taken in the cycle the buffer hands out
// its last result. Dimension registers of 0 act as 1 and values above MAX_DIM
// act as MAX_DIM. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`include "elevation_grid_mesher_defines.svh"

module elevation_grid_mesher #(
    parameter int MAX_DIM = egm_pkg::DEF_MAX_DIM
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [egm_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [egm_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // sample requests
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [egm_pkg::HEIGHT_W-1:0]   i_height_sample,
    input  logic                                  i_last_sample,
    // result requests
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [egm_pkg::KIND_W-1:0]            o_kind,
    output logic [egm_pkg::POS_W-1:0]             o_pos_x,
    output logic signed [egm_pkg::HEIGHT_W-1:0]   o_pos_y,
    output logic [egm_pkg::POS_W-1:0]             o_pos_z,
    output logic [egm_pkg::CORNER_W-1:0]          o_corner_a,
    output logic [egm_pkg::CORNER_W-1:0]          o_corner_b,
    output logic [egm_pkg::CORNER_W-1:0]          o_corner_c,
    output logic                                  o_run_end
);
    import egm_pkg::*;

    // Counter width holds MAX_DIM-1, dimension width holds MAX_DIM itself
    localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EW    = ((DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W) + 1;

    // ---------------- configuration registers ----------------
    logic [CFG_DIM_W-1:0] r_x_columns;
    logic [CFG_DIM_W-1:0] r_z_rows;
    logic [SPACING_W-1:0] r_x_spacing;
    logic [SPACING_W-1:0] r_z_spacing;
    logic                 r_ccw;

    // ---------------- grid walk state ----------------
    logic [CNT_W-1:0]    r_col,     n_col;
    logic [CNT_W-1:0]    r_row,     n_row;
    logic [VCOUNT_W-1:0] r_vcount,  n_vcount;
    logic [POS_W-1:0]    r_xpos,    n_xpos;
    logic [POS_W-1:0]    r_zpos,    n_zpos;
    logic                r_discard, n_discard;

    // ---------------- result buffer of one sample ----------------
    logic [1:0]                 r_job_cnt, n_job_cnt;   // results still to hand out
    logic [1:0]                 r_job_idx, n_job_idx;   // next slot to hand out
    logic                       r_job_err;
    logic [POS_W-1:0]           r_job_px;
    logic signed [HEIGHT_W-1:0] r_job_py;
    logic [POS_W-1:0]           r_job_pz;
    logic [CORNER_W-1:0]        r_job_a;
    logic [CORNER_W-1:0]        r_job_b1;
    logic [CORNER_W-1:0]        r_job_c1;
    logic [CORNER_W-1:0]        r_job_b2;
    logic [CORNER_W-1:0]        r_job_c2;

    // ---------------- output register ----------------
    logic                       r_out_valid;
    t_kind                      r_out_kind;
    logic [POS_W-1:0]           r_out_px;
    logic signed [HEIGHT_W-1:0] r_out_py;
    logic [POS_W-1:0]           r_out_pz;
    logic [CORNER_W-1:0]        r_out_a;
    logic [CORNER_W-1:0]        r_out_b;
    logic [CORNER_W-1:0]        r_out_c;
    logic                       r_out_end;

    // ---------------- handshake ----------------
    logic out_free;
    logic pop;
    logic in_ready;
    logic accept;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_job_cnt != 2'd0) && out_free;
    // Take a new sample once the buffer is empty or hands out its last result now
    assign in_ready = (r_job_cnt == 2'd0) || ((r_job_cnt == 2'd1) && out_free);
    assign accept   = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    // ---------------- per-sample computation ----------------
    logic [EW-1:0]       cols_ext, rows_ext;
    logic [EW-1:0]       nx, nz;
    logic [EW-1:0]       col_next, row_next;
    logic                row_end, final_pos, closes_cell;
    logic [CORNER_W-1:0] v, nx_c, corner_a, left, up;
    logic [1:0]          acc_cnt;
    logic                acc_err;

    always_comb begin
        // Clamp dimensions into 1..MAX_DIM
        cols_ext = EW'(r_x_columns);
        rows_ext = EW'(r_z_rows);
        if (cols_ext == '0) begin
            nx = EW'(1);
        end else if (cols_ext > EW'(MAX_DIM)) begin
            nx = EW'(MAX_DIM);
        end else begin
            nx = cols_ext;
        end
        if (rows_ext == '0) begin
            nz = EW'(1);
        end else if (rows_ext > EW'(MAX_DIM)) begin
            nz = EW'(MAX_DIM);
        end else begin
            nz = rows_ext;
        end

        col_next    = EW'(r_col) + EW'(1);
        row_next    = EW'(r_row) + EW'(1);
        row_end     = col_next >= nx;
        final_pos   = row_end && (row_next >= nz);
        closes_cell = (r_col != '0) && (r_row != '0);

        // Cell corners, indices wrap at the corner width
        v        = r_vcount[CORNER_W-1:0];
        nx_c     = CORNER_W'(nx);
        corner_a = v - nx_c - CORNER_W'(1);
        left     = v - CORNER_W'(1);
        up       = v - nx_c;

        // Walk state advance
        n_col     = r_col;
        n_row     = r_row;
        n_vcount  = r_vcount;
        n_xpos    = r_xpos;
        n_zpos    = r_zpos;
        n_discard = r_discard;
        acc_cnt   = 2'd0;
        acc_err   = 1'b0;

        if (r_discard) begin
            // Drop the sample; a marked one ends the drop run
            if (i_last_sample) begin
                n_discard = 1'b0;
                n_col     = '0;
                n_row     = '0;
                n_vcount  = '0;
                n_xpos    = '0;
                n_zpos    = '0;
            end
        end else if (i_last_sample != final_pos) begin
            // Count mismatch: one mismatch result, restart the grid
            acc_cnt  = 2'd1;
            acc_err  = 1'b1;
            n_col    = '0;
            n_row    = '0;
            n_vcount = '0;
            n_xpos   = '0;
            n_zpos   = '0;
            if (!i_last_sample) begin
                n_discard = 1'b1;
            end
        end else begin
            acc_cnt = closes_cell ? 2'd3 : 2'd1;
            if (final_pos) begin
                n_col    = '0;
                n_row    = '0;
                n_vcount = '0;
                n_xpos   = '0;
                n_zpos   = '0;
            end else if (row_end) begin
                n_col    = '0;
                n_row    = r_row + CNT_W'(1);
                n_xpos   = '0;
                n_zpos   = r_zpos + POS_W'(r_z_spacing);
                n_vcount = r_vcount + VCOUNT_W'(1);
            end else begin
                n_col    = r_col + CNT_W'(1);
                n_xpos   = r_xpos + POS_W'(r_x_spacing);
                n_vcount = r_vcount + VCOUNT_W'(1);
            end
        end

        // Buffer bookkeeping
        if (accept) begin
            n_job_cnt = acc_cnt;
            n_job_idx = SLOT_FIRST;
        end else if (pop) begin
            n_job_cnt = r_job_cnt - 2'd1;
            n_job_idx = r_job_idx + 2'd1;
        end else begin
            n_job_cnt = r_job_cnt;
            n_job_idx = r_job_idx;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_columns <= RST_X_COLUMNS;
            r_z_rows    <= RST_Z_ROWS;
            r_x_spacing <= RST_X_SPACING;
            r_z_spacing <= RST_Z_SPACING;
            r_ccw       <= RST_CCW;
            r_col       <= '0;
            r_row       <= '0;
            r_vcount    <= '0;
            r_xpos      <= '0;
            r_zpos      <= '0;
            r_discard   <= 1'b0;
            r_job_cnt   <= '0;
            r_job_idx   <= SLOT_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_X_COLUMNS: begin
                        r_x_columns <= i_cfg_wdata[CFG_DIM_W-1:0];
                    end
                    REG_Z_ROWS: begin
                        r_z_rows <= i_cfg_wdata[CFG_DIM_W-1:0];
                    end
                    REG_X_SPACING: begin
                        r_x_spacing <= i_cfg_wdata[SPACING_W-1:0];
                    end
                    REG_Z_SPACING: begin
                        r_z_spacing <= i_cfg_wdata[SPACING_W-1:0];
                    end
                    REG_CCW: begin
                        r_ccw <= i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_vcount  <= n_vcount;
                r_xpos    <= n_xpos;
                r_zpos    <= n_zpos;
                r_discard <= n_discard;
            end

            r_job_cnt <= n_job_cnt;
            r_job_idx <= n_job_idx;

            if (out_free) begin
                r_out_valid <= pop;
            end
        end

        // Payload: no reset needed
        if (accept) begin
            r_job_err <= acc_err;
            r_job_px  <= r_xpos;
            r_job_py  <= i_height_sample;
            r_job_pz  <= r_zpos;
            r_job_a   <= corner_a;
            r_job_b1  <= r_ccw ? left : v;
            r_job_c1  <= r_ccw ? v    : left;
            r_job_b2  <= r_ccw ? v    : up;
            r_job_c2  <= r_ccw ? up   : v;
        end

        if (pop) begin
            r_out_end <= (r_job_cnt == 2'd1);
            unique case (r_job_idx)
                SLOT_FIRST: begin
                    r_out_kind <= r_job_err ? KIND_MISMATCH : KIND_VERTEX;
                    r_out_px   <= r_job_err ? '0 : r_job_px;
                    r_out_py   <= r_job_err ? '0 : r_job_py;
                    r_out_pz   <= r_job_err ? '0 : r_job_pz;
                    r_out_a    <= '0;
                    r_out_b    <= '0;
                    r_out_c    <= '0;
                end
                SLOT_TRI_FIRST: begin
                    r_out_kind <= KIND_TRIANGLE;
                    r_out_px   <= '0;
                    r_out_py   <= '0;
                    r_out_pz   <= '0;
                    r_out_a    <= r_job_a;
                    r_out_b    <= r_job_b1;
                    r_out_c    <= r_job_c1;
                end
                SLOT_TRI_SECOND: begin
                    r_out_kind <= KIND_TRIANGLE;
                    r_out_px   <= '0;
                    r_out_py   <= '0;
                    r_out_pz   <= '0;
                    r_out_a    <= r_job_a;
                    r_out_b    <= r_job_b2;
                    r_out_c    <= r_job_c2;
                end
                default: begin
                    r_out_kind <= KIND_MISMATCH;
                    r_out_px   <= '0;
                    r_out_py   <= '0;
                    r_out_pz   <= '0;
                    r_out_a    <= '0;
                    r_out_b    <= '0;
                    r_out_c    <= '0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_pos_x     = r_out_px;
    assign o_pos_y     = r_out_py;
    assign o_pos_z     = r_out_pz;
    assign o_corner_a  = r_out_a;
    assign o_corner_b  = r_out_b;
    assign o_corner_c  = r_out_c;
    assign o_run_end   = r_out_end;

    // ---------------- checks ----------------
    // Hold off new samples while two or more results of the current one remain
    `EGM_ASSERT_IMP(a_stall_when_busy, i_clk, i_rst_n, r_job_cnt > 2'd1, o_in_stall)
    // A mismatch result always ends its sample's run
    `EGM_ASSERT_IMP(a_mismatch_ends, i_clk, i_rst_n, r_out_valid && (r_out_kind == KIND_MISMATCH), r_out_end)
    // Dropped samples leave nothing to hand out
    `EGM_ASSERT_NXT(a_drop_silent, i_clk, i_rst_n, accept && r_discard, r_job_cnt == 2'd0)
    // Results of one sample leave without gaps
    `EGM_ASSERT_NXT(a_run_gapless, i_clk, i_rst_n, r_out_valid && !i_out_stall && !r_out_end, r_out_valid)

endmodule
